### hdl/cic_pkg.sv
// Shared types, codes and helper functions for the cascaded interrupt controller.
// No dependencies; imported by cic_engine and the top level.
`default_nettype none

package cic_pkg;

    // Command codes carried by each input beat
    typedef enum logic [2:0] {
        CMD_RAISE = 3'd0,
        CMD_LOWER = 3'd1,
        CMD_ACK   = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    // Initialisation sequence position, one-hot
    typedef enum logic [3:0] {
        INIT_IDLE = 4'b0001,
        INIT_ICW2 = 4'b0010,
        INIT_ICW3 = 4'b0100,
        INIT_ICW4 = 4'b1000
    } init_t;

    localparam int unsigned NUM_CHIPS    = 2;
    localparam int unsigned CHIP_MASTER  = 0;
    localparam int unsigned CHIP_SLAVE   = 1;
    localparam logic [2:0]  CASCADE_LINE = 3'd2;

    localparam logic [7:0] MASK_RESET_MASTER = 8'hB8;
    localparam logic [7:0] MASK_RESET_SLAVE  = 8'hFF;
    localparam logic [4:0] BASE_RESET_MASTER = 5'(8'h08 >> 3);
    localparam logic [4:0] BASE_RESET_SLAVE  = 5'(8'h70 >> 3);

    // Command byte decode fields
    localparam int unsigned ICW1_BIT     = 4;
    localparam int unsigned OCW3_BIT     = 3;
    localparam int unsigned OCW3_RR_BIT  = 1;
    localparam logic [2:0]  OCW2_NS_EOI  = 3'b001;
    localparam logic [2:0]  OCW2_SP_EOI  = 3'b011;

    typedef struct packed {
        cmd_t       command;
        logic [3:0] irq_line;
        logic       chip_select;
        logic       reg_select;
        logic [7:0] write_data;
    } cic_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vector_valid;
        logic [7:0] vector;
    } cic_result_t;

    // Lowest set bit: bit 3 flags an empty byte, bits 2:0 give the index
    function automatic logic [3:0] lowest_set(input logic [7:0] v);
        logic [3:0] r;
        r = 4'b1000;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b0, 3'(i)};
            end
        end
        return r;
    endfunction

    // Bits 0 up to and including idx
    function automatic logic [7:0] upto_mask(input logic [2:0] idx);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = (3'(i) <= idx);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/cascaded_interrupt_controller_top.sv
// Top level of the cascaded master/slave interrupt controller: stream handshake,
// input and result registers. Depends on cic_pkg and cic_engine.
//
//  channel | dir | tdata                                 | tuser
//  --------+-----+---------------------------------------+-------------------------------
//  s_*     | in  | [3:0] irq_line, [11:4] write_data     | [2:0] command, [3] chip_select,
//          |     |                                       | [4] reg_select
//  m_*     | out | [7:0] read_data, [15:8] vector        | [0] vector_valid
//
// One beat per cycle sustained while m_tready is high; each beat passes through the input
// register and then the result register onto m_*, with the priority encode and state
// update between the two registers. Every input beat yields exactly one output beat.
// A stalled m_tready holds the result register; the input register keeps taking a
// beat until it too is full. Reset is asynchronous, active low, and loads the
// power-on masks and vector bases.
`default_nettype none

module cascaded_interrupt_controller_top (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [15:0] s_tdata,   // [3:0] irq_line, [11:4] write_data, [15:12] zero
    input  wire [4:0]  s_tuser,   // [2:0] command, [3] chip_select, [4] reg_select
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata,  // [7:0] read_data, [15:8] vector
    output logic       m_tuser    // [0] vector_valid
);
    import cic_pkg::*;

    cic_item_t   item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    cic_result_t res_reg;
    cic_result_t res_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        s_accept;
    logic        advance;

    // Handshake: the input register drains whenever the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    cic_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (res_next)
    );

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat and the result
    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            item_reg.command     <= cmd_t'(s_tuser[2:0]);
            item_reg.chip_select <= s_tuser[3];
            item_reg.reg_select  <= s_tuser[4];
            item_reg.irq_line    <= s_tdata[3:0];
            item_reg.write_data  <= s_tdata[11:4];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.vector, res_reg.read_data};
    assign m_tuser  = res_reg.vector_valid;

endmodule

`default_nettype wire

### hdl/cic_engine.sv
// Register file and combinational command logic for the master/slave controller pair.
// Depends on cic_pkg; instantiated by cascaded_interrupt_controller_top.
`default_nettype none

module cic_engine (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  fire,
    input  cic_pkg::cic_item_t   item,
    output cic_pkg::cic_result_t result
);
    import cic_pkg::*;

    logic [7:0] mask_reg [NUM_CHIPS];
    logic [7:0] mask_next [NUM_CHIPS];
    logic [7:0] request_reg [NUM_CHIPS];
    logic [7:0] request_next [NUM_CHIPS];
    logic [7:0] service_reg [NUM_CHIPS];
    logic [7:0] service_next [NUM_CHIPS];
    logic [4:0] base_reg [NUM_CHIPS];
    logic [4:0] base_next [NUM_CHIPS];
    init_t      step_reg [NUM_CHIPS];
    init_t      step_next [NUM_CHIPS];
    logic       icw4_reg [NUM_CHIPS];
    logic       icw4_next [NUM_CHIPS];
    logic       rsel_reg [NUM_CHIPS];
    logic       rsel_next [NUM_CHIPS];

    logic [3:0] master_pick;
    logic [3:0] slave_pick;
    logic       master_blocked;
    logic [3:0] eoi_pick [NUM_CHIPS];

    // Priority resolution on current state
    assign master_pick    = lowest_set(request_reg[CHIP_MASTER] & ~mask_reg[CHIP_MASTER]);
    assign slave_pick     = lowest_set(request_reg[CHIP_SLAVE] & ~mask_reg[CHIP_SLAVE]);
    assign master_blocked = |(service_reg[CHIP_MASTER] & upto_mask(master_pick[2:0]));
    assign eoi_pick[CHIP_MASTER] = lowest_set(service_reg[CHIP_MASTER]);
    assign eoi_pick[CHIP_SLAVE]  = lowest_set(service_reg[CHIP_SLAVE]);

    // Next state and result for the beat in the input register
    always_comb
    begin
        for (int c = 0; c < NUM_CHIPS; c++) begin
            mask_next[c]    = mask_reg[c];
            request_next[c] = request_reg[c];
            service_next[c] = service_reg[c];
            base_next[c]    = base_reg[c];
            step_next[c]    = step_reg[c];
            icw4_next[c]    = icw4_reg[c];
            rsel_next[c]    = rsel_reg[c];
        end
        result = '0;

        unique case (item.command)
            CMD_RAISE:
            begin
                if (!item.irq_line[3]) begin
                    request_next[CHIP_MASTER] = request_reg[CHIP_MASTER]
                                                | (8'b1 << item.irq_line[2:0]);
                end else begin
                    request_next[CHIP_SLAVE]  = request_reg[CHIP_SLAVE]
                                                | (8'b1 << item.irq_line[2:0]);
                    request_next[CHIP_MASTER] = request_reg[CHIP_MASTER]
                                                | (8'b1 << CASCADE_LINE);
                end
            end
            CMD_LOWER:
            begin
                if (!item.irq_line[3]) begin
                    request_next[CHIP_MASTER] = request_reg[CHIP_MASTER]
                                                & ~(8'b1 << item.irq_line[2:0]);
                end else begin
                    request_next[CHIP_SLAVE]  = request_reg[CHIP_SLAVE]
                                                & ~(8'b1 << item.irq_line[2:0]);
                end
            end
            CMD_ACK:
            begin
                if (!master_pick[3] && !master_blocked) begin
                    request_next[CHIP_MASTER] = request_reg[CHIP_MASTER]
                                                & ~(8'b1 << master_pick[2:0]);
                    if (master_pick[2:0] == CASCADE_LINE) begin
                        // Cascade: the slave supplies the vector, if it has one
                        if (!slave_pick[3]) begin
                            request_next[CHIP_SLAVE] = request_reg[CHIP_SLAVE]
                                                       & ~(8'b1 << slave_pick[2:0]);
                            service_next[CHIP_SLAVE] = service_reg[CHIP_SLAVE]
                                                       | (8'b1 << slave_pick[2:0]);
                            service_next[CHIP_MASTER] = service_reg[CHIP_MASTER]
                                                        | (8'b1 << CASCADE_LINE);
                            result.vector_valid = 1'b1;
                            result.vector = {base_reg[CHIP_SLAVE], slave_pick[2:0]};
                        end
                    end else begin
                        service_next[CHIP_MASTER] = service_reg[CHIP_MASTER]
                                                    | (8'b1 << master_pick[2:0]);
                        result.vector_valid = 1'b1;
                        result.vector = {base_reg[CHIP_MASTER], master_pick[2:0]};
                    end
                end
            end
            CMD_WRITE:
            begin
                for (int c = 0; c < NUM_CHIPS; c++) begin
                    if (item.chip_select == 1'(c)) begin
                        if (!item.reg_select) begin
                            // Command port: ICW1, OCW3 or OCW2
                            if (item.write_data[ICW1_BIT]) begin
                                step_next[c]    = INIT_ICW2;
                                mask_next[c]    = '0;
                                service_next[c] = '0;
                                request_next[c] = '0;
                                icw4_next[c]    = item.write_data[0];
                            end else if (item.write_data[OCW3_BIT]) begin
                                if (item.write_data[OCW3_RR_BIT]) begin
                                    rsel_next[c] = item.write_data[0];
                                end
                            end else if (item.write_data[7:5] == OCW2_NS_EOI) begin
                                if (!eoi_pick[c][3]) begin
                                    service_next[c] = service_reg[c]
                                                      & ~(8'b1 << eoi_pick[c][2:0]);
                                end
                            end else if (item.write_data[7:5] == OCW2_SP_EOI) begin
                                service_next[c] = service_reg[c]
                                                  & ~(8'b1 << item.write_data[2:0]);
                            end
                        end else begin
                            // Data port: advance the init sequence or load the mask
                            unique case (step_reg[c])
                                INIT_ICW2:
                                begin
                                    base_next[c] = item.write_data[7:3];
                                    step_next[c] = INIT_ICW3;
                                end
                                INIT_ICW3:
                                begin
                                    step_next[c] = icw4_reg[c] ? INIT_ICW4 : INIT_IDLE;
                                end
                                INIT_ICW4:
                                begin
                                    step_next[c] = INIT_IDLE;
                                end
                                default:
                                begin
                                    mask_next[c] = item.write_data;
                                end
                            endcase
                        end
                    end
                end
            end
            CMD_READ:
            begin
                if (!item.reg_select) begin
                    if (item.chip_select) begin
                        result.read_data = rsel_reg[CHIP_SLAVE] ? service_reg[CHIP_SLAVE]
                                                                : request_reg[CHIP_SLAVE];
                    end else begin
                        result.read_data = rsel_reg[CHIP_MASTER] ? service_reg[CHIP_MASTER]
                                                                 : request_reg[CHIP_MASTER];
                    end
                end else begin
                    result.read_data = item.chip_select ? mask_reg[CHIP_SLAVE]
                                                        : mask_reg[CHIP_MASTER];
                end
            end
            default:
            begin
                // Unused codes: no state change, zero result
            end
        endcase
    end

    // Commit state on each beat that leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg[CHIP_MASTER] <= MASK_RESET_MASTER;
            mask_reg[CHIP_SLAVE]  <= MASK_RESET_SLAVE;
            base_reg[CHIP_MASTER] <= BASE_RESET_MASTER;
            base_reg[CHIP_SLAVE]  <= BASE_RESET_SLAVE;
            for (int c = 0; c < NUM_CHIPS; c++) begin
                request_reg[c] <= '0;
                service_reg[c] <= '0;
                step_reg[c]    <= INIT_IDLE;
                icw4_reg[c]    <= 1'b0;
                rsel_reg[c]    <= 1'b0;
            end
        end else if (fire) begin
            for (int c = 0; c < NUM_CHIPS; c++) begin
                mask_reg[c]    <= mask_next[c];
                request_reg[c] <= request_next[c];
                service_reg[c] <= service_next[c];
                base_reg[c]    <= base_next[c];
                step_reg[c]    <= step_next[c];
                icw4_reg[c]    <= icw4_next[c];
                rsel_reg[c]    <= rsel_next[c];
            end
        end
    end

endmodule

`default_nettype wire
